// ===== design/sdrs_pkg.sv =====
// Shared types, field widths and codes of the sorted disk request scheduler.
package sdrs_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;

	localparam int TAG_W  = 8;
	localparam int OFF_W  = 28;
	localparam int CNT_W  = 16;
	localparam int STAT_W = 2;

	localparam logic ACT_SUBMIT = 1'b0;
	localparam logic ACT_DONE   = 1'b1;

	localparam logic KIND_ISSUE = 1'b0;
	localparam logic KIND_REPLY = 1'b1;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BUSY  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOMEM = 2'd2;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic             wr;
		logic [OFF_W-1:0] off;
		logic [CNT_W-1:0] cnt;
	} entry_t;

endpackage

// ===== design/sdrs_mem.sv =====
// Request store and forward link memories, one read address, registered read data.
module sdrs_mem
	import sdrs_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF,
	parameter int IW    = $clog2(QUEUE_DEPTH_DEF)
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [IW-1:0] rd_addr,
	input  logic          st_we,
	input  logic [IW-1:0] st_wa,
	input  entry_t        st_wd,
	input  logic          ln_we,
	input  logic [IW-1:0] ln_wa,
	input  logic [IW-1:0] ln_wd,
	output entry_t        st_rd,
	output logic [IW-1:0] ln_rd
);

	entry_t        store_mem [DEPTH];
	logic [IW-1:0] link_mem  [DEPTH];

	always_ff @(posedge clk) begin
		if (st_we) begin
			store_mem[st_wa] <= st_wd;
		end
		if (ln_we) begin
			link_mem[ln_wa] <= ln_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			st_rd <= store_mem[rd_addr];
			ln_rd <= link_mem[rd_addr];
		end
	end

endmodule

// ===== design/sorted_disk_request_scheduler.sv =====
// C-LOOK disk request scheduler: sorted linked request ring and issue sequencer.
// One word at a time. A submit does a free slot scan (up to QUEUE_DEPTH), a sorted
// walk over the entries passed and a predecessor search (up to QUEUE_DEPTH steps),
// walk and search steps each using the single memory read port, plus output waits.
// A done event reads and counts down the current entry; when the request completes
// and entries remain, a removal walk and an issue follow.
// Reset (arst_n low) clears valid bits and control; memory contents stay undefined.
module sorted_disk_request_scheduler
	import sdrs_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic              action,
	input  logic [TAG_W-1:0]  caller_tag,
	input  logic              is_write,
	input  logic [OFF_W-1:0]  sector_offset,
	input  logic [CNT_W-1:0]  sector_count,
	input  logic              device_ready,
	input  logic              device_busy,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic              result_kind,
	output logic [TAG_W-1:0]  reply_tag,
	output logic [STAT_W-1:0] reply_status,
	output logic              issue_write,
	output logic [OFF_W-1:0]  issue_offset,
	output logic [CNT_W-1:0]  issue_count,
	output logic              last_result
);

	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	// sequencer states, one-hot
	typedef enum logic [15:0] {
		S_IDLE   = 16'h0001,
		S_SCAN   = 16'h0002,  // look for a free slot
		S_WRNEW  = 16'h0004,  // store new request
		S_WALK   = 16'h0008,  // sorted walk: read
		S_WALK_D = 16'h0010,  // sorted walk: compare
		S_PRED   = 16'h0020,  // predecessor search: read
		S_PRED_D = 16'h0040,  // predecessor search: compare, patch link
		S_LINK2  = 16'h0080,  // link new entry forward
		S_ISS_RD = 16'h0100,
		S_ISS_D  = 16'h0200,  // emit issue, write advance
		S_BUSY   = 16'h0400,  // emit busy reply
		S_DN_RD  = 16'h0800,
		S_DN_D   = 16'h1000,  // count down
		S_OK     = 16'h2000,  // emit ok reply
		S_RM     = 16'h4000,  // remove current entry
		S_NOMEM  = 16'h8000
	} state_t;

	state_t state_q;

	// latched input word
	logic [TAG_W-1:0] tag_q;
	logic             wr_q;
	logic [OFF_W-1:0] off_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             rdy_q;

	logic [QUEUE_DEPTH-1:0] valid_q;
	logic [IW-1:0] lowest_q, cur_q, s_q, at_q, t_q, p_q, nx_q;
	logic          active_q, lt_low_q, mode_ins_q, rm_issue_q;
	logic [CW-1:0] used_q, i_q, k_q, scan_q;

	// memory port
	logic          rd_en, st_we, ln_we;
	logic [IW-1:0] rd_addr, st_wa, ln_wa, ln_wd;
	entry_t        st_wd, st_rd;
	logic [IW-1:0] ln_rd;

	logic          out_free, out_ld;
	logic          o_kind, o_wr, o_last;
	logic [TAG_W-1:0]  o_tag;
	logic [STAT_W-1:0] o_stat;
	logic [OFF_W-1:0]  o_off;
	logic [CNT_W-1:0]  o_cnt;

	logic             off_less, pred_hit, pred_end, stays;
	logic [CNT_W-1:0] cnt_dn;
	logic [IW-1:0]    link_val;

	sdrs_mem #(.DEPTH(QUEUE_DEPTH), .IW(IW)) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.st_we   (st_we),
		.st_wa   (st_wa),
		.st_wd   (st_wd),
		.ln_we   (ln_we),
		.ln_wa   (ln_wa),
		.ln_wd   (ln_wd),
		.st_rd   (st_rd),
		.ln_rd   (ln_rd)
	);

	assign req_stall = (state_q != S_IDLE);
	assign out_free  = !rsp_valid || !rsp_stall;

	assign off_less = off_q < st_rd.off;
	assign pred_end = (k_q == DEPTH_C);
	assign pred_hit = (ln_rd == t_q);
	assign link_val = mode_ins_q ? s_q : nx_q;
	// a done event counts down only with ready set and a nonzero count
	assign cnt_dn   = (rdy_q && st_rd.cnt != '0) ? st_rd.cnt - CNT_W'(1) : st_rd.cnt;
	// queue still holds entries after removing the current one
	assign stays    = (nx_q != cur_q) && (used_q > CW'(1));

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = cur_q;
		st_we   = 1'b0;
		st_wa   = cur_q;
		st_wd   = st_rd;
		ln_we   = 1'b0;
		ln_wa   = p_q;
		ln_wd   = link_val;
		out_ld  = 1'b0;
		o_kind  = KIND_REPLY;
		o_tag   = st_rd.tag;
		o_stat  = STAT_OK;
		o_wr    = 1'b0;
		o_off   = '0;
		o_cnt   = '0;
		o_last  = 1'b1;
		case (state_q)
			S_WRNEW: begin
				st_we = 1'b1;
				st_wa = s_q;
				st_wd = '{tag: tag_q, wr: wr_q, off: off_q, cnt: cnt_q};
				if (used_q == '0) begin
					ln_we = 1'b1;
					ln_wa = s_q;
					ln_wd = s_q;
				end
			end
			S_WALK: begin
				rd_en   = 1'b1;
				rd_addr = at_q;
			end
			S_PRED: begin
				rd_en   = 1'b1;
				rd_addr = p_q;
				if (pred_end) begin
					ln_we = 1'b1;
					ln_wa = t_q;
				end
			end
			S_PRED_D: begin
				if (pred_hit) begin
					ln_we = 1'b1;
				end
			end
			S_LINK2: begin
				ln_we = 1'b1;
				ln_wa = s_q;
				ln_wd = at_q;
			end
			S_ISS_RD, S_DN_RD: begin
				rd_en = 1'b1;
			end
			S_ISS_D: begin
				if (out_free) begin
					out_ld = 1'b1;
					o_kind = KIND_ISSUE;
					o_wr   = st_rd.wr;
					o_off  = st_rd.off;
					o_cnt  = st_rd.cnt;
					o_last = !busy_q;
					if (!busy_q && st_rd.wr) begin
						st_we     = 1'b1;
						st_wd.off = st_rd.off + OFF_W'(1);
						st_wd.cnt = (st_rd.cnt != '0) ? st_rd.cnt - CNT_W'(1) : st_rd.cnt;
					end
				end
			end
			S_BUSY: begin
				out_ld = out_free;
				o_stat = STAT_BUSY;
			end
			S_DN_D: begin
				st_we     = 1'b1;
				st_wd.cnt = cnt_dn;
			end
			S_OK: begin
				out_ld = out_free;
				o_last = !stays;
			end
			S_NOMEM: begin
				out_ld = out_free;
				o_tag  = tag_q;
				o_stat = STAT_NOMEM;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			tag_q      <= '0;
			wr_q       <= 1'b0;
			off_q      <= '0;
			cnt_q      <= '0;
			busy_q     <= 1'b0;
			rdy_q      <= 1'b0;
			valid_q    <= '0;
			lowest_q   <= '0;
			cur_q      <= '0;
			s_q        <= '0;
			at_q       <= '0;
			t_q        <= '0;
			p_q        <= '0;
			nx_q       <= '0;
			active_q   <= 1'b0;
			lt_low_q   <= 1'b0;
			mode_ins_q <= 1'b0;
			rm_issue_q <= 1'b0;
			used_q     <= '0;
			i_q        <= '0;
			k_q        <= '0;
			scan_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						tag_q  <= caller_tag;
						wr_q   <= is_write;
						off_q  <= sector_offset;
						cnt_q  <= sector_count;
						busy_q <= device_busy;
						rdy_q  <= device_ready;
						scan_q <= '0;
						if (action == ACT_SUBMIT) begin
							state_q <= (used_q >= DEPTH_C) ? S_NOMEM : S_SCAN;
						end else if (active_q) begin
							state_q <= S_DN_RD;
						end
					end
				end
				S_SCAN: begin
					if (scan_q == DEPTH_C) begin
						state_q <= S_NOMEM;
					end else if (!valid_q[scan_q[IW-1:0]]) begin
						s_q     <= scan_q[IW-1:0];
						state_q <= S_WRNEW;
					end else begin
						scan_q <= scan_q + CW'(1);
					end
				end
				S_WRNEW: begin
					valid_q[s_q] <= 1'b1;
					if (used_q == '0) begin
						lowest_q <= s_q;
						used_q   <= used_q + CW'(1);
						if (!active_q) begin
							cur_q    <= s_q;
							active_q <= 1'b1;
							state_q  <= S_ISS_RD;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						at_q    <= lowest_q;
						i_q     <= '0;
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (i_q == used_q) begin
						// wrapped: new entry goes at the tail
						t_q        <= at_q;
						p_q        <= at_q;
						k_q        <= '0;
						mode_ins_q <= 1'b1;
						state_q    <= S_PRED;
					end else begin
						state_q <= S_WALK_D;
					end
				end
				S_WALK_D: begin
					if (i_q == '0) begin
						lt_low_q <= off_less;
					end
					if (off_less) begin
						t_q        <= at_q;
						p_q        <= at_q;
						k_q        <= '0;
						mode_ins_q <= 1'b1;
						state_q    <= S_PRED;
					end else begin
						at_q    <= ln_rd;
						i_q     <= i_q + CW'(1);
						state_q <= S_WALK;
					end
				end
				S_PRED, S_PRED_D: begin
					if ((state_q == S_PRED && pred_end) || (state_q == S_PRED_D && pred_hit)) begin
						// predecessor link patched this cycle
						if (mode_ins_q) begin
							state_q <= S_LINK2;
						end else begin
							if (lowest_q == cur_q) begin
								lowest_q <= nx_q;
							end
							cur_q   <= nx_q;
							state_q <= rm_issue_q ? S_ISS_RD : S_IDLE;
						end
					end else if (state_q == S_PRED) begin
						state_q <= S_PRED_D;
					end else begin
						p_q     <= ln_rd;
						k_q     <= k_q + CW'(1);
						state_q <= S_PRED;
					end
				end
				S_LINK2: begin
					if (lt_low_q) begin
						lowest_q <= s_q;
					end
					used_q <= used_q + CW'(1);
					if (!active_q) begin
						cur_q    <= s_q;
						active_q <= 1'b1;
						state_q  <= S_ISS_RD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_ISS_RD: begin
					state_q <= S_ISS_D;
				end
				S_ISS_D: begin
					if (out_free) begin
						nx_q    <= ln_rd;
						state_q <= busy_q ? S_BUSY : S_IDLE;
					end
				end
				S_BUSY: begin
					if (out_free) begin
						rm_issue_q <= 1'b0;
						state_q    <= S_RM;
					end
				end
				S_DN_RD: begin
					state_q <= S_DN_D;
				end
				S_DN_D: begin
					nx_q    <= ln_rd;
					state_q <= (cnt_dn == '0) ? S_OK : S_IDLE;
				end
				S_OK: begin
					if (out_free) begin
						rm_issue_q <= 1'b1;
						state_q    <= S_RM;
					end
				end
				S_RM: begin
					valid_q[cur_q] <= 1'b0;
					if (!stays) begin
						active_q <= 1'b0;
						used_q   <= '0;
						state_q  <= S_IDLE;
					end else begin
						used_q     <= used_q - CW'(1);
						t_q        <= cur_q;
						p_q        <= cur_q;
						k_q        <= '0;
						mode_ins_q <= 1'b0;
						state_q    <= S_PRED;
					end
				end
				S_NOMEM: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid    <= 1'b0;
			result_kind  <= KIND_ISSUE;
			reply_tag    <= '0;
			reply_status <= STAT_OK;
			issue_write  <= 1'b0;
			issue_offset <= '0;
			issue_count  <= '0;
			last_result  <= 1'b0;
		end else if (out_ld) begin
			rsp_valid    <= 1'b1;
			result_kind  <= o_kind;
			reply_tag    <= o_tag;
			reply_status <= o_stat;
			issue_write  <= o_wr;
			issue_offset <= o_off;
			issue_count  <= o_cnt;
			last_result  <= o_last;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

endmodule

// ===== design/sdrs_checker.sv =====
// Port-level checker of the sorted disk request scheduler, with its bind.
module sdrs_checker
	import sdrs_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_stall,
	input logic              action,
	input logic [TAG_W-1:0]  caller_tag,
	input logic              is_write,
	input logic [OFF_W-1:0]  sector_offset,
	input logic [CNT_W-1:0]  sector_count,
	input logic              device_ready,
	input logic              device_busy,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input logic              result_kind,
	input logic [TAG_W-1:0]  reply_tag,
	input logic [STAT_W-1:0] reply_status,
	input logic              issue_write,
	input logic [OFF_W-1:0]  issue_offset,
	input logic [CNT_W-1:0]  issue_count,
	input logic              last_result
);

	a_reply_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && result_kind == KIND_REPLY |->
			!issue_write && issue_offset == '0 && issue_count == '0)
		else $error("reply word carries issue fields");

	a_issue_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && result_kind == KIND_ISSUE |-> reply_status == STAT_OK)
		else $error("issue word carries a status");

	a_busy_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (reply_status == STAT_BUSY || reply_status == STAT_NOMEM) |->
			last_result && result_kind == KIND_REPLY)
		else $error("busy or no_memory reply not final");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(reply_tag) && $stable(last_result))
		else $error("stalled result word changed");

endmodule

bind sorted_disk_request_scheduler sdrs_checker u_sdrs_checker (.*);
